@@ src/plc_pkg.sv @@
// Constants and coefficient tables for the photodiode lux pipeline.
package plc_pkg;

   localparam int RAW_W   = 16;
   localparam int FACT_W  = 19;
   localparam int CH_W    = 25;
   localparam int COEF_W  = 10;
   localparam int LUX_W   = 21;
   localparam int SEG_N   = 8;
   localparam int BRK_N   = SEG_N - 1;
   localparam int SEG_W   = $clog2(SEG_N);
   localparam int FRAC_CH  = 10;
   localparam int FRAC_LUX = 14;
   localparam int CH_PROD_W  = RAW_W + FACT_W;
   localparam int BRK_PROD_W = CH_W + COEF_W + 1;
   localparam int LUX_PROD_W = CH_W + COEF_W;

   typedef logic [COEF_W-1:0] coef_type;
   typedef logic [SEG_W-1:0]  seg_type;

   typedef enum logic [1:0] {
      CSR_GAIN_HIGH        = 2'd0,
      CSR_INTEGRATION_TIME = 2'd1,
      CSR_PACKAGE_CS       = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ITIME_SHORT  = 2'd0,
      ITIME_MID    = 2'd1,
      ITIME_LONG   = 2'd2,
      ITIME_MANUAL = 2'd3
   } itime_type;

   localparam logic [14:0] TIME_FACTOR_SHORT = 15'h7517;
   localparam logic [14:0] TIME_FACTOR_MID   = 15'h0fe7;
   localparam logic [14:0] TIME_FACTOR_UNIT  = 15'h0400;

   localparam coef_type BRK_TAB [0:1][0:BRK_N-1] = '{
      '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
      '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
   };

   localparam coef_type OFFS_TAB [0:1][0:SEG_N-1] = '{
      '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
      '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
   };

   localparam coef_type SLOPE_TAB [0:1][0:SEG_N-1] = '{
      '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
      '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
   };

endpackage

@@ src/photodiode_lux_calc_unit.sv @@
// Pipelined lux calculation from visible+IR and IR photodiode counts.
// An accepted request moves through s1, s2, s3, s4 and the output register.
// Throughput: one request per cycle; busy stays low, the five stages never stall.
// Stages: time scaling, breakpoint products, segment pick, channel products, round.
// Reset clears the stage valid bits and sets gain 0, integration time 2, package 0.
module photodiode_lux_calc_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [plc_pkg::RAW_W-1:0]     req_count_visible_ir,
   input  logic [plc_pkg::RAW_W-1:0]     req_count_ir,
   output logic                          rsp_valid,
   output logic [plc_pkg::LUX_W-1:0]     rsp_lux,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [1:0]                    csr_write_data
);

   logic                 gain_high_ff;
   plc_pkg::itime_type   itime_ff;
   logic                 package_cs_ff;

   logic [plc_pkg::FACT_W-1:0]    factor;
   logic [plc_pkg::CH_PROD_W-1:0] prod0, prod1;

   logic                        s1_valid_ff;
   logic [plc_pkg::CH_W-1:0]    s1_ch0_ff, s1_ch1_ff;

   logic                          s2_valid_ff;
   logic [plc_pkg::CH_W-1:0]      s2_ch0_ff, s2_ch1_ff;
   logic [plc_pkg::BRK_PROD_W-1:0] s2_brk_ff [plc_pkg::BRK_N];

   logic [plc_pkg::BRK_PROD_W-1:0] ch1_scaled;
   plc_pkg::seg_type               seg;

   logic                        s3_valid_ff;
   logic [plc_pkg::CH_W-1:0]    s3_ch0_ff, s3_ch1_ff;
   plc_pkg::coef_type           s3_offs_ff, s3_slope_ff;

   logic                          s4_valid_ff;
   logic [plc_pkg::LUX_PROD_W-1:0] s4_pos_ff, s4_neg_ff;

   logic [plc_pkg::LUX_PROD_W:0]   diff;
   logic [plc_pkg::LUX_PROD_W:0]   rounded;

   logic                        rsp_valid_ff;
   logic [plc_pkg::LUX_W-1:0]   rsp_lux_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_high_ff  <= 1'b0;
         itime_ff      <= plc_pkg::ITIME_LONG;
         package_cs_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            plc_pkg::CSR_GAIN_HIGH:        gain_high_ff  <= csr_write_data[0];
            plc_pkg::CSR_INTEGRATION_TIME: itime_ff      <= plc_pkg::itime_type'(csr_write_data);
            plc_pkg::CSR_PACKAGE_CS:       package_cs_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [14:0] base;
      case (itime_ff)
         plc_pkg::ITIME_SHORT: base = plc_pkg::TIME_FACTOR_SHORT;
         plc_pkg::ITIME_MID:   base = plc_pkg::TIME_FACTOR_MID;
         default:              base = plc_pkg::TIME_FACTOR_UNIT;
      endcase
      factor = gain_high_ff ? {4'b0, base} : {base, 4'b0};
   end

   assign prod0 = plc_pkg::CH_PROD_W'(req_count_visible_ir) * plc_pkg::CH_PROD_W'(factor);
   assign prod1 = plc_pkg::CH_PROD_W'(req_count_ir) * plc_pkg::CH_PROD_W'(factor);

   // stage 1: scale both counts
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start;
      s1_ch0_ff <= prod0[plc_pkg::FRAC_CH +: plc_pkg::CH_W];
      s1_ch1_ff <= prod1[plc_pkg::FRAC_CH +: plc_pkg::CH_W];
   end

   // stage 2: ch0 times each breakpoint edge (2k+1)
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_ch0_ff <= s1_ch0_ff;
      s2_ch1_ff <= s1_ch1_ff;
      for (int i = 0; i < plc_pkg::BRK_N; i++) begin
         s2_brk_ff[i] <= plc_pkg::BRK_PROD_W'(s1_ch0_ff)
                       * plc_pkg::BRK_PROD_W'({plc_pkg::BRK_TAB[package_cs_ff][i], 1'b1});
      end
   end

   // stage 3: pick segment where ch1*1024 < (2k+1)*ch0
   assign ch1_scaled = {1'b0, s2_ch1_ff, 10'b0};

   always_comb begin
      seg = plc_pkg::seg_type'(plc_pkg::BRK_N);
      for (int i = plc_pkg::BRK_N - 1; i >= 0; i--) begin
         if (ch1_scaled < s2_brk_ff[i]) seg = plc_pkg::seg_type'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      s3_ch0_ff   <= s2_ch0_ff;
      s3_ch1_ff   <= s2_ch1_ff;
      s3_offs_ff  <= plc_pkg::OFFS_TAB[package_cs_ff][seg];
      s3_slope_ff <= plc_pkg::SLOPE_TAB[package_cs_ff][seg];
   end

   // stage 4: channel products
   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
      s4_pos_ff <= plc_pkg::LUX_PROD_W'(s3_ch0_ff) * plc_pkg::LUX_PROD_W'(s3_offs_ff);
      s4_neg_ff <= plc_pkg::LUX_PROD_W'(s3_ch1_ff) * plc_pkg::LUX_PROD_W'(s3_slope_ff);
   end

   // stage 5: clamp, round, drop fraction
   assign diff    = (s4_pos_ff > s4_neg_ff) ? {1'b0, s4_pos_ff - s4_neg_ff} : '0;
   assign rounded = diff + (plc_pkg::LUX_PROD_W + 1)'(1 << (plc_pkg::FRAC_LUX - 1));

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s4_valid_ff;
      rsp_lux_ff <= rounded[plc_pkg::FRAC_LUX +: plc_pkg::LUX_W];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lux   = rsp_lux_ff;

endmodule

@@ sim/photodiode_lux_calc_unit_test.sv @@
// Self-checking testbench for the photodiode lux pipeline: directed and random requests.
module photodiode_lux_calc_unit_test;

   localparam int PIPE_DEPTH = 5;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam longint unsigned SCALE_SHORT = 64'h7517;
   localparam longint unsigned SCALE_MID   = 64'h0fe7;
   localparam longint unsigned SCALE_UNIT  = 64'h0400;

   localparam logic [9:0] SEG_LIMIT [0:1][0:6] = '{
      '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
      '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
   };
   localparam logic [9:0] SEG_OFFSET [0:1][0:7] = '{
      '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
      '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
   };
   localparam logic [9:0] SEG_SLOPE [0:1][0:7] = '{
      '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
      '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
   };

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [plc_pkg::RAW_W-1:0]  req_count_visible_ir;
   logic [plc_pkg::RAW_W-1:0]  req_count_ir;
   logic                       rsp_valid;
   logic [plc_pkg::LUX_W-1:0]  rsp_lux;
   logic                       csr_write_enable;
   logic [1:0]                 csr_index;
   logic [1:0]                 csr_write_data;

   logic                       gain_high_cfg;
   plc_pkg::itime_type         itime_cfg;
   logic                       package_cs_cfg;

   logic [plc_pkg::LUX_W-1:0]  expected_lux [$];
   int                         idle_percent;
   int                         mismatches;
   int                         requests_sent;
   int                         results_checked;

   photodiode_lux_calc_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_count_visible_ir (req_count_visible_ir),
      .req_count_ir         (req_count_ir),
      .rsp_valid            (rsp_valid),
      .rsp_lux              (rsp_lux),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [plc_pkg::LUX_W-1:0] predict_lux(
         input logic [plc_pkg::RAW_W-1:0] visible_ir,
         input logic [plc_pkg::RAW_W-1:0] ir_only);
      longint unsigned factor;
      longint unsigned ch0;
      longint unsigned ch1;
      longint unsigned ratio;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned lux;
      int              seg;
      case (itime_cfg)
         plc_pkg::ITIME_SHORT: factor = SCALE_SHORT;
         plc_pkg::ITIME_MID:   factor = SCALE_MID;
         default:              factor = SCALE_UNIT;
      endcase
      if (!gain_high_cfg) begin
         factor = factor << 4;
      end
      ch0 = (64'(visible_ir) * factor) >> 10;
      ch1 = (64'(ir_only) * factor) >> 10;
      ratio = 0;
      if (ch0 != 0) begin
         ratio = (ch1 << 10) / ch0;
      end
      ratio = (ratio + 1) >> 1;
      seg = 7;
      for (int i = 6; i >= 0; i--) begin
         if (ratio <= 64'(SEG_LIMIT[package_cs_cfg][i])) begin
            seg = i;
         end
      end
      pos = ch0 * 64'(SEG_OFFSET[package_cs_cfg][seg]);
      neg = ch1 * 64'(SEG_SLOPE[package_cs_cfg][seg]);
      lux = (pos > neg) ? (pos - neg) : 64'd0;
      lux = (lux + 64'd8192) >> 14;
      return lux[plc_pkg::LUX_W-1:0];
   endfunction

   // Entered and left at a falling edge; start stays high for a following request.
   task automatic send_request(input logic [plc_pkg::RAW_W-1:0] visible_ir,
                               input logic [plc_pkg::RAW_W-1:0] ir_only);
      while ($urandom_range(99) < idle_percent) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_count_visible_ir = visible_ir;
      req_count_ir = ir_only;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      expected_lux.push_back(predict_lux(visible_ir, ir_only));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      start = 1'b0;
      while (expected_lux.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [1:0] data);
      drain_pipeline();
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (index == plc_pkg::CSR_GAIN_HIGH) begin
         gain_high_cfg = data[0];
      end else if (index == plc_pkg::CSR_INTEGRATION_TIME) begin
         itime_cfg = plc_pkg::itime_type'(data);
      end else if (index == plc_pkg::CSR_PACKAGE_CS) begin
         package_cs_cfg = data[0];
      end
   endtask

   task automatic check_reset_defaults();
      idle_percent = 0;
      send_request(16'd0, 16'd0);
      send_request(16'hffff, 16'd0);
      send_request(16'd0, 16'hffff);
      send_request(16'hffff, 16'hffff);
      send_request(16'd1, 16'd1);
      drain_pipeline();
   endtask

   // Wide data keeps only the low bits; the spare index changes nothing.
   task automatic check_register_writes();
      write_csr(plc_pkg::CSR_GAIN_HIGH, 2'b11);
      send_request(16'd40000, 16'd12000);
      write_csr(plc_pkg::CSR_GAIN_HIGH, 2'b10);
      send_request(16'd40000, 16'd12000);
      write_csr(plc_pkg::CSR_PACKAGE_CS, 2'b11);
      send_request(16'd40000, 16'd12000);
      write_csr(CSR_UNUSED, 2'b11);
      send_request(16'd40000, 16'd12000);
      write_csr(plc_pkg::CSR_PACKAGE_CS, 2'b10);
      drain_pipeline();
   endtask

   // Unit scaling makes the ratio land exactly on each breakpoint, then just past the last.
   task automatic check_segment_boundaries();
      write_csr(plc_pkg::CSR_GAIN_HIGH, 2'd1);
      write_csr(plc_pkg::CSR_INTEGRATION_TIME, plc_pkg::ITIME_MANUAL);
      for (int pkg = 0; pkg < 2; pkg++) begin
         write_csr(plc_pkg::CSR_PACKAGE_CS, 2'(pkg));
         for (int i = 0; i < 7; i++) begin
            send_request(16'd4096, 16'(SEG_LIMIT[pkg][i]) << 3);
         end
         send_request(16'd4096, (16'(SEG_LIMIT[pkg][6]) << 3) + 16'd8);
      end
      drain_pipeline();
   endtask

   task automatic check_random_settings();
      logic [plc_pkg::RAW_W-1:0] visible_ir;
      logic [plc_pkg::RAW_W-1:0] ir_only;
      int unsigned               scaled;
      for (int combo = 0; combo < 16; combo++) begin
         write_csr(plc_pkg::CSR_GAIN_HIGH, 2'(combo & 1));
         write_csr(plc_pkg::CSR_INTEGRATION_TIME, 2'((combo >> 1) & 3));
         write_csr(plc_pkg::CSR_PACKAGE_CS, 2'((combo >> 3) & 1));
         for (int phase = 0; phase < 3; phase++) begin
            idle_percent = (phase == 0) ? 0 : (phase == 1) ? 51 : 24;
            for (int n = 0; n < 27; n++) begin
               visible_ir = 16'($urandom);
               ir_only = 16'($urandom);
               case ($urandom_range(9))
                  0, 1: begin
                  end
                  2, 3, 4, 5, 6: begin
                     scaled = (int'(visible_ir) * $urandom_range(0, 1500)) >> 10;
                     ir_only = (scaled > 65535) ? 16'hffff : 16'(scaled);
                  end
                  7: begin
                     visible_ir = 16'($urandom_range(0, 15));
                     ir_only = 16'($urandom_range(0, 15));
                  end
                  default: begin
                     visible_ir = $urandom_range(1) ? 16'hffff : 16'd0;
                     ir_only = $urandom_range(1) ? 16'hffff : 16'($urandom_range(0, 3));
                  end
               endcase
               send_request(visible_ir, ir_only);
            end
         end
      end
      drain_pipeline();
   endtask

   always @(posedge clock) begin : check_results
      logic [plc_pkg::LUX_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_lux.size() == 0) begin
            mismatches++;
            $error("lux: no request outstanding, actual %0d", rsp_lux);
         end else begin
            want = expected_lux.pop_front();
            results_checked++;
            if (rsp_lux !== want) begin
               mismatches++;
               $error("lux mismatch: expected %0d, actual %0d", want, rsp_lux);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_count_visible_ir = '0;
      req_count_ir = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      gain_high_cfg = 1'b0;
      itime_cfg = plc_pkg::ITIME_LONG;
      package_cs_cfg = 1'b0;
      idle_percent = 0;
      mismatches = 0;
      requests_sent = 0;
      results_checked = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      check_reset_defaults();
      check_register_writes();
      check_segment_boundaries();
      check_random_settings();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      $display("Sent %0d requests across every gain, timing and package setting,", requests_sent);
      $display("with and without sender gaps; %0d lux results compared.", results_checked);
      if (mismatches == 0 && expected_lux.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ photodiode_lux_calc_unit.f @@
src/plc_pkg.sv
src/photodiode_lux_calc_unit.sv
sim/photodiode_lux_calc_unit_test.sv
